// File: hdl/rdcm_pkg.sv
// ----------------------------------------------------------------------------
// Radial distortion coordinate map: shared package
// Field widths, register codes, reset values and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package rdcm_pkg;

    // Port field widths.
    localparam int PIX_W      = 11;
    localparam int DIM_W      = 12;
    localparam int K_W        = 21;
    localparam int OUT_W      = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_ROWS   = 2'd0,
        CFG_FRAME_COLS   = 2'd1,
        CFG_DISTORTION_K = 2'd2
    } t_cfg_idx;

    // Register values after reset.
    localparam logic [DIM_W-1:0] ROWS_RST = 12'd480;
    localparam logic [DIM_W-1:0] COLS_RST = 12'd640;
    localparam logic [K_W-1:0]   K_RST    = 21'd0;

    // Internal widths that follow from the fixed field widths alone.
    localparam int ABS_W = 12;   // |2*pix - dim| <= 4095
    localparam int SQ_W  = 24;   // square of one offset
    localparam int S_W   = 25;   // sum of both squares
    localparam int MAG_W = 33;   // |offset| * 2000000
    localparam int P_W   = 46;   // k * S, signed
    localparam int D_W   = 47;   // 4000000 + k * S, signed
    localparam int DV_W  = 47;   // 2 * D for a positive D

    // Constants of the division model, scaled to half-pixel offsets.
    localparam int K_SCALE = 2000000;
    localparam int D_BIAS  = 4000000;

    // Output saturation limits.
    localparam int OUT_MAX = 1048575;
    localparam int OUT_MIN = -1048576;

endpackage

// File: hdl/radial_distortion_coord_map.sv
// ----------------------------------------------------------------------------
// Radial distortion coordinate map
// Maps an output pixel to its source coordinate under a radial division
// model, one pixel per clock unless stalled, with saturated fixed-point results.
// ----------------------------------------------------------------------------
// A transaction passes through the front stages, the divider and the output
// register; Q_W, the quotient width, is 22 for FRAC_BITS up to 9 and
// FRAC_BITS + 13 above. Throughput: one transaction per cycle unless the
// output stalls, as the restoring divider retires one quotient bit per stage.
// Reset (synchronous, active low) empties the pipeline and loads the frame
// size registers with 480 x 640 and the coefficient with 0.
module radial_distortion_coord_map #(
    parameter int MAX_DIM   = 2048,
    parameter int FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rdcm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rdcm_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // pixel input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [rdcm_pkg::PIX_W-1:0]          i_pix_row,
    input  logic [rdcm_pkg::PIX_W-1:0]          i_pix_col,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [rdcm_pkg::OUT_W-1:0]   o_src_col,
    output logic signed [rdcm_pkg::OUT_W-1:0]   o_src_row,
    output logic                                o_den_bad,
    output logic                                o_clipped
);
    import rdcm_pkg::*;

    // The numerator is 2*|offset|*2000000*2^FRAC_BITS + D. Its width is set
    // by whichever of the two terms is wider.
    localparam int N_W = ((34 + FRAC_BITS) > 46) ? (35 + FRAC_BITS) : 47;
    // Quotient bits kept by the divider. Any quotient at or above 2^Q_W
    // saturates the result whatever the center is, so the divider only
    // needs to flag that case instead of computing the upper bits.
    localparam int Q_W = (FRAC_BITS > 9) ? (FRAC_BITS + 13) : 22;
    // Width of the signed sum of offset term and center.
    localparam int SUM_W = Q_W + 2;
    // Pipeline depth: six front stages, Q_W + 1 divider stages, one output.
    localparam int L = 8 + Q_W;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(OUT_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(OUT_MIN);

    // One divider stage carries both axes, which share the divisor 2*D.
    typedef struct packed {
        logic [DV_W-1:0]  p_r;
        logic [DV_W-1:0]  p_c;
        logic [N_W-1:0]   n_r;
        logic [N_W-1:0]   n_c;
        logic [Q_W-1:0]   q_r;
        logic [Q_W-1:0]   q_c;
        logic             ovf_r;
        logic             ovf_c;
        logic [DV_W-1:0]  dv;
        logic             bad;
        logic             neg_r;
        logic             neg_c;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
    } t_div;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             hit;
    } t_sat;

    // ------------------------------------------------------------------
    // Configuration registers. Writes are taken every cycle; an unknown
    // index is dropped.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]     r_rows;
    logic [DIM_W-1:0]     r_cols;
    logic signed [K_W-1:0] r_k;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RST;
            r_cols <= COLS_RST;
            r_k    <= K_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_ROWS:   r_rows <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_COLS:   r_cols <= i_cfg_data[DIM_W-1:0];
                CFG_DISTORTION_K: r_k    <= i_cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. The whole pipeline moves together whenever the
    // output register is empty or its transaction completes this cycle;
    // valid bits shift along with the data so bubbles pass through
    // untouched and a stall freezes every stage in place.
    // ------------------------------------------------------------------
    logic         pipe_adv;
    logic [L-1:0] r_v;

    assign pipe_adv = !r_v[L-1] || i_ready;
    assign o_ready  = pipe_adv;
    assign o_valid  = r_v[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (pipe_adv) begin
            r_v <= {r_v[L-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: clamp the frame size and form offsets in half pixels,
    // 2*pix - dim, split into magnitude and sign.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]     n0_rows;
    logic [DIM_W-1:0]     n0_cols;
    logic signed [DIM_W:0] n0_d2r;
    logic signed [DIM_W:0] n0_d2c;

    logic [ABS_W-1:0] r0_abs_r;
    logic [ABS_W-1:0] r0_abs_c;
    logic             r0_neg_r;
    logic             r0_neg_c;
    logic [DIM_W-1:0] r0_rows;
    logic [DIM_W-1:0] r0_cols;

    always_comb begin
        n0_rows = (int'(r_rows) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_rows;
        n0_cols = (int'(r_cols) > MAX_DIM) ? DIM_W'(MAX_DIM) : r_cols;
        n0_d2r  = $signed({1'b0, i_pix_row, 1'b0}) - $signed({1'b0, n0_rows});
        n0_d2c  = $signed({1'b0, i_pix_col, 1'b0}) - $signed({1'b0, n0_cols});
    end

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r0_neg_r <= n0_d2r[DIM_W];
            r0_neg_c <= n0_d2c[DIM_W];
            r0_abs_r <= n0_d2r[DIM_W] ? ABS_W'(-n0_d2r) : ABS_W'(n0_d2r);
            r0_abs_c <= n0_d2c[DIM_W] ? ABS_W'(-n0_d2c) : ABS_W'(n0_d2c);
            r0_rows  <= n0_rows;
            r0_cols  <= n0_cols;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares of both offsets and the scaled offset magnitudes.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]  r1_sq_r;
    logic [SQ_W-1:0]  r1_sq_c;
    logic [MAG_W-1:0] r1_mag_r;
    logic [MAG_W-1:0] r1_mag_c;
    logic             r1_neg_r;
    logic             r1_neg_c;
    logic [DIM_W-1:0] r1_rows;
    logic [DIM_W-1:0] r1_cols;

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r1_sq_r  <= SQ_W'(r0_abs_r) * SQ_W'(r0_abs_r);
            r1_sq_c  <= SQ_W'(r0_abs_c) * SQ_W'(r0_abs_c);
            r1_mag_r <= MAG_W'(r0_abs_r) * MAG_W'(K_SCALE);
            r1_mag_c <= MAG_W'(r0_abs_c) * MAG_W'(K_SCALE);
            r1_neg_r <= r0_neg_r;
            r1_neg_c <= r0_neg_c;
            r1_rows  <= r0_rows;
            r1_cols  <= r0_cols;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squared radius in quarter pixels.
    // ------------------------------------------------------------------
    logic [S_W-1:0]   r2_s;
    logic [MAG_W-1:0] r2_mag_r;
    logic [MAG_W-1:0] r2_mag_c;
    logic             r2_neg_r;
    logic             r2_neg_c;
    logic [DIM_W-1:0] r2_rows;
    logic [DIM_W-1:0] r2_cols;

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r2_s     <= S_W'(r1_sq_r) + S_W'(r1_sq_c);
            r2_mag_r <= r1_mag_r;
            r2_mag_c <= r1_mag_c;
            r2_neg_r <= r1_neg_r;
            r2_neg_c <= r1_neg_c;
            r2_rows  <= r1_rows;
            r2_cols  <= r1_cols;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: coefficient times squared radius.
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] n3_prod;
    logic signed [P_W-1:0] r3_prod;
    logic [MAG_W-1:0]      r3_mag_r;
    logic [MAG_W-1:0]      r3_mag_c;
    logic                  r3_neg_r;
    logic                  r3_neg_c;
    logic [DIM_W-1:0]      r3_rows;
    logic [DIM_W-1:0]      r3_cols;

    assign n3_prod = P_W'(r_k) * P_W'($signed({1'b0, r2_s}));

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r3_prod  <= n3_prod;
            r3_mag_r <= r2_mag_r;
            r3_mag_c <= r2_mag_c;
            r3_neg_r <= r2_neg_r;
            r3_neg_c <= r2_neg_c;
            r3_rows  <= r2_rows;
            r3_cols  <= r2_cols;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: the denominator D, scaled by 4000000.
    // ------------------------------------------------------------------
    logic signed [D_W-1:0] r4_den;
    logic [MAG_W-1:0]      r4_mag_r;
    logic [MAG_W-1:0]      r4_mag_c;
    logic                  r4_neg_r;
    logic                  r4_neg_c;
    logic [DIM_W-1:0]      r4_rows;
    logic [DIM_W-1:0]      r4_cols;

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r4_den   <= $signed({r3_prod[P_W-1], r3_prod}) + $signed(D_W'(D_BIAS));
            r4_mag_r <= r3_mag_r;
            r4_mag_c <= r3_mag_c;
            r4_neg_r <= r3_neg_r;
            r4_neg_c <= r3_neg_c;
            r4_rows  <= r3_rows;
            r4_cols  <= r3_cols;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: round-to-nearest numerators 2*|a| + D and divisor 2*D.
    // A denominator of zero or less is flagged here; the divider still
    // runs on it, and its output is masked at the end.
    // ------------------------------------------------------------------
    logic [N_W-1:0]   r5_n_r;
    logic [N_W-1:0]   r5_n_c;
    logic [DV_W-1:0]  r5_dv;
    logic             r5_bad;
    logic             r5_neg_r;
    logic             r5_neg_c;
    logic [DIM_W-1:0] r5_rows;
    logic [DIM_W-1:0] r5_cols;

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r5_n_r   <= (N_W'(r4_mag_r) << (FRAC_BITS + 1)) + N_W'($unsigned(r4_den));
            r5_n_c   <= (N_W'(r4_mag_c) << (FRAC_BITS + 1)) + N_W'($unsigned(r4_den));
            r5_dv    <= {r4_den[D_W-2:0], 1'b0};
            r5_bad   <= r4_den[D_W-1] || (r4_den == '0);
            r5_neg_r <= r4_neg_r;
            r5_neg_c <= r4_neg_c;
            r5_rows  <= r4_rows;
            r5_cols  <= r4_cols;
        end
    end

    // ------------------------------------------------------------------
    // Divider. The first stage checks whether the quotient reaches 2^Q_W
    // (the upper numerator bits alone already hold the divisor) and loads
    // the partial remainder. Each following stage brings down one
    // numerator bit and retires one quotient bit, most significant first.
    // ------------------------------------------------------------------
    t_div r_dv [0:Q_W];
    t_div n_dv0;

    always_comb begin
        n_dv0       = '0;
        n_dv0.p_r   = DV_W'(r5_n_r >> Q_W);
        n_dv0.p_c   = DV_W'(r5_n_c >> Q_W);
        n_dv0.ovf_r = (n_dv0.p_r >= r5_dv);
        n_dv0.ovf_c = (n_dv0.p_c >= r5_dv);
        n_dv0.n_r   = r5_n_r;
        n_dv0.n_c   = r5_n_c;
        n_dv0.dv    = r5_dv;
        n_dv0.bad   = r5_bad;
        n_dv0.neg_r = r5_neg_r;
        n_dv0.neg_c = r5_neg_c;
        n_dv0.rows  = r5_rows;
        n_dv0.cols  = r5_cols;
    end

    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar j = 0; j < Q_W; j++) begin : g_div
        localparam int B = Q_W - 1 - j;

        t_div          n_dv;
        logic [DV_W:0] trial_r;
        logic [DV_W:0] trial_c;

        always_comb begin
            n_dv    = r_dv[j];
            trial_r = {r_dv[j].p_r, r_dv[j].n_r[B]};
            trial_c = {r_dv[j].p_c, r_dv[j].n_c[B]};
            if (trial_r >= {1'b0, r_dv[j].dv}) begin
                n_dv.p_r    = DV_W'(trial_r - {1'b0, r_dv[j].dv});
                n_dv.q_r[B] = 1'b1;
            end else begin
                n_dv.p_r = trial_r[DV_W-1:0];
            end
            if (trial_c >= {1'b0, r_dv[j].dv}) begin
                n_dv.p_c    = DV_W'(trial_c - {1'b0, r_dv[j].dv});
                n_dv.q_c[B] = 1'b1;
            end else begin
                n_dv.p_c = trial_c[DV_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (pipe_adv) begin
                r_dv[j+1] <= n_dv;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: apply the sign of the offset, add the center
    // dim * 2^(FRAC_BITS-1) and saturate. A quotient that overflowed the
    // divider saturates in the direction of its sign.
    // ------------------------------------------------------------------
    function automatic t_sat sat_coord(logic [Q_W-1:0] q, logic neg, logic ovf,
                                       logic [DIM_W-1:0] dim);
        logic signed [SUM_W-1:0] off;
        logic signed [SUM_W-1:0] ctr;
        logic signed [SUM_W-1:0] sum;
        t_sat                    res;
        off = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        ctr = $signed(SUM_W'({dim, {(FRAC_BITS - 1){1'b0}}}));
        sum = off + ctr;
        if (ovf) begin
            res.hit = 1'b1;
            res.val = neg ? OUT_W'(SUM_MIN) : OUT_W'(SUM_MAX);
        end else if (sum > SUM_MAX) begin
            res.hit = 1'b1;
            res.val = OUT_W'(SUM_MAX);
        end else if (sum < SUM_MIN) begin
            res.hit = 1'b1;
            res.val = OUT_W'(SUM_MIN);
        end else begin
            res.hit = 1'b0;
            res.val = sum[OUT_W-1:0];
        end
        return res;
    endfunction

    t_sat n_col;
    t_sat n_row;

    logic signed [OUT_W-1:0] r_src_col;
    logic signed [OUT_W-1:0] r_src_row;
    logic                    r_den_bad;
    logic                    r_clipped;

    always_comb begin
        n_col = sat_coord(r_dv[Q_W].q_c, r_dv[Q_W].neg_c, r_dv[Q_W].ovf_c,
                          r_dv[Q_W].cols);
        n_row = sat_coord(r_dv[Q_W].q_r, r_dv[Q_W].neg_r, r_dv[Q_W].ovf_r,
                          r_dv[Q_W].rows);
    end

    // A bad denominator forces both coordinates and the clip flag to zero.
    always_ff @(posedge i_clk) begin
        if (pipe_adv) begin
            if (r_dv[Q_W].bad) begin
                r_src_col <= '0;
                r_src_row <= '0;
                r_den_bad <= 1'b1;
                r_clipped <= 1'b0;
            end else begin
                r_src_col <= n_col.val;
                r_src_row <= n_row.val;
                r_den_bad <= 1'b0;
                r_clipped <= n_col.hit || n_row.hit;
            end
        end
    end

    assign o_src_col = r_src_col;
    assign o_src_row = r_src_row;
    assign o_den_bad = r_den_bad;
    assign o_clipped = r_clipped;

endmodule
